FILE: rtl/bsl_pkg.sv
// ----------------------------------------------------------------------------
// Bounded sequential list package
// Shared codes, payload structs and cell control for the list block.
// ----------------------------------------------------------------------------
package bsl_pkg;

    localparam int DEF_CAPACITY   = 64;
    localparam int DEF_DATA_WIDTH = 32;

    // Field widths of the transfer payloads.
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 7;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 6;
    localparam int COUNT_W  = 7;

    // Match flags are examined this many cells at a time during a find.
    localparam int GROUP   = 8;
    localparam int GROUP_W = 3;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ERASE      = 3'd5;
    localparam logic [CMD_W-1:0] CMD_FIND       = 3'd6;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]          command;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_in;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic                found;
        logic [INDEX_W-1:0]  found_index;
        logic [COUNT_W-1:0]  count;
    } t_out;

    // Broadcast to every cell of the chain.
    typedef struct packed {
        logic shift_up;    // open a gap at the position, load the value there
        logic shift_down;  // close the gap at the position
        logic load;        // write the value at the position only
        logic capture;     // latch the compare result into the match flag
        logic scan;        // move match flags one group toward the head
    } t_cell_ctl;

endpackage

FILE: rtl/bounded_sequential_list.sv
// ----------------------------------------------------------------------------
// Bounded sequential list
// Ordered list of signed words kept in a chain of cells, with push, pop,
// insert, erase and find commands.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload      Direction
//  input     i_in_valid / o_in_ready   i_in_data    command into the list
//  output    o_out_valid / i_out_ready o_out_data   status, find result, count
//
//  Every command except find completes directly: the cells shift, hold or
//  load in parallel and the result lands in the output register.
//  A find first latches a match flag in every cell, then examines the flags
//  in groups of eight at the head of the chain, where they are priority
//  encoded. The scan stops at the first group with a hit or at the group
//  that holds the last entry; for an empty list it ends after the first group.
//  Reset clears the entry count, the state and the output valid; entries
//  themselves are not cleared and are never read above the count.
//  A stalled output transfer holds the result and blocks new commands.
// ----------------------------------------------------------------------------
module bounded_sequential_list
    import bsl_pkg::*;
#(
    parameter int CAPACITY   = DEF_CAPACITY,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    // Count width, compare width (never narrower than the position field) and
    // width of the find scan base, which plus one group can run past the end.
    localparam int CW  = $clog2(CAPACITY + 1);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int BWC = $clog2(CAPACITY + GROUP + 1);
    localparam int BW  = (BWC > COUNT_W) ? BWC : COUNT_W;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    logic                  r_state;
    logic                  n_state;
    logic [CW-1:0]         r_count;
    logic [CW-1:0]         n_count;
    logic [BW-1:0]         r_base;
    logic [BW-1:0]         n_base;
    logic                  r_out_valid;
    logic                  n_out_valid;
    t_out                  r_out;
    t_out                  n_out;

    t_cell_ctl             w_ctl;
    logic [PW-1:0]         w_pos;
    logic [PW-1:0]         w_pos_in;
    logic [PW-1:0]         w_count_ext;
    logic [DATA_WIDTH-1:0] w_value;
    logic                  w_in_acc;
    logic                  w_full;
    logic                  w_empty;
    logic [GROUP-1:0]      w_group;
    logic [GROUP_W-1:0]    w_enc;
    logic [BW-1:0]         w_hit_idx;
    logic                  w_scan_end;

    logic [DATA_WIDTH-1:0] w_word [0:CAPACITY];
    logic [CAPACITY+GROUP-1:0] w_flag;

    // Only the low DATA_WIDTH bits of the value are stored and compared;
    // a wider store sign extends the signed field.
    assign w_value = DATA_WIDTH'(i_in_data.value);

    assign w_pos_in    = PW'(i_in_data.position);
    assign w_count_ext = PW'(r_count);
    assign w_full      = (r_count == CW'(CAPACITY));
    assign w_empty     = (r_count == '0);

    // A new command is taken only between commands, and only when the output
    // register is empty or handing its result over in this cycle.
    assign o_in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_acc   = i_in_valid && o_in_ready;

    // The chain: cell 0 is the head of the list.
    assign w_word[CAPACITY] = '0;
    assign w_flag[CAPACITY+GROUP-1:CAPACITY] = '0;

    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic [DATA_WIDTH-1:0] w_prev;
        if (gi == 0) begin : g_head
            assign w_prev = '0;
        end else begin : g_body
            assign w_prev = w_word[gi-1];
        end

        bsl_cell #(
            .INDEX      (gi),
            .PW         (PW),
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (w_ctl),
            .i_pos       (w_pos),
            .i_count     (w_count_ext),
            .i_value     (w_value),
            .i_prev_word (w_prev),
            .i_next_word (w_word[gi+1]),
            .i_next_flag (w_flag[gi+GROUP]),
            .o_word      (w_word[gi]),
            .o_flag      (w_flag[gi])
        );
    end

    // Priority encode the group of flags now sitting at the head of the chain.
    assign w_group = w_flag[GROUP-1:0];

    always_comb begin
        w_enc = '0;
        for (int k = GROUP - 1; k >= 0; k--) begin
            if (w_group[k]) begin
                w_enc = GROUP_W'(k);
            end
        end
    end

    assign w_hit_idx  = r_base + BW'(w_enc);
    assign w_scan_end = ((r_base + BW'(GROUP)) >= BW'(r_count));

    always_comb begin
        logic [PW-1:0] v_cnt;

        n_state     = r_state;
        n_count     = r_count;
        n_base      = r_base;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        w_ctl       = '0;
        w_pos       = w_pos_in;
        v_cnt       = '0;

        if (r_state == S_IDLE) begin
            if (w_in_acc) begin
                n_out.status      = ST_OK;
                n_out.found       = 1'b0;
                n_out.found_index = '0;
                n_out_valid       = 1'b1;
                case (i_in_data.command)
                    CMD_PUSH_BACK: begin
                        w_pos = w_count_ext;
                        if (w_full) begin
                            n_out.status = ST_FULL;
                        end else begin
                            w_ctl.load = 1'b1;
                            n_count    = r_count + 1'b1;
                        end
                    end
                    CMD_PUSH_FRONT: begin
                        w_pos = '0;
                        if (w_full) begin
                            n_out.status = ST_FULL;
                        end else begin
                            w_ctl.shift_up = 1'b1;
                            n_count        = r_count + 1'b1;
                        end
                    end
                    CMD_POP_BACK: begin
                        if (w_empty) begin
                            n_out.status = ST_EMPTY;
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end
                    CMD_POP_FRONT: begin
                        w_pos = '0;
                        if (w_empty) begin
                            n_out.status = ST_EMPTY;
                        end else begin
                            w_ctl.shift_down = 1'b1;
                            n_count          = r_count - 1'b1;
                        end
                    end
                    CMD_INSERT: begin
                        // The range check takes precedence over the full check.
                        if (w_pos_in > w_count_ext) begin
                            n_out.status = ST_RANGE;
                        end else if (w_full) begin
                            n_out.status = ST_FULL;
                        end else begin
                            w_ctl.shift_up = 1'b1;
                            n_count        = r_count + 1'b1;
                        end
                    end
                    CMD_ERASE: begin
                        if (w_empty) begin
                            n_out.status = ST_EMPTY;
                        end else if (w_pos_in >= w_count_ext) begin
                            n_out.status = ST_RANGE;
                        end else begin
                            w_ctl.shift_down = 1'b1;
                            n_count          = r_count - 1'b1;
                        end
                    end
                    CMD_FIND: begin
                        // Every cell compares now; the result follows the scan.
                        w_ctl.capture = 1'b1;
                        n_out_valid   = 1'b0;
                        n_base        = '0;
                        n_state       = S_SCAN;
                    end
                    default: begin
                    end
                endcase
                v_cnt       = PW'(n_count);
                n_out.count = v_cnt[COUNT_W-1:0];
            end
        end else begin
            if ((|w_group) || w_scan_end) begin
                n_out.status      = ST_OK;
                n_out.found       = |w_group;
                n_out.found_index = (|w_group) ? w_hit_idx[INDEX_W-1:0] : '0;
                n_out.count       = w_count_ext[COUNT_W-1:0];
                n_out_valid       = 1'b1;
                n_state           = S_IDLE;
            end else begin
                w_ctl.scan = 1'b1;
                n_base     = r_base + BW'(GROUP);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_base      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_base      <= n_base;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef SYNTHESIS
    // The list never holds more entries than it has cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count exceeds capacity");

    // While a find scans, no other result can be waiting.
    a_scan_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_out_valid)
        else $error("output occupied during find scan");

    // Any command other than find presents its result in the next cycle.
    a_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_in_data.command != CMD_FIND)) |=> o_out_valid)
        else $error("single-cycle command produced no result");

    // The count moves only as the direct effect of an accepted command.
    a_count_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != $past(r_count)) |-> $past(w_in_acc))
        else $error("entry count changed without a command");

    // A hit is reported only with an ok status.
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.found) |-> (o_out_data.status == ST_OK))
        else $error("find hit reported with error status");
`endif

endmodule

FILE: rtl/bsl_cell.sv
// ----------------------------------------------------------------------------
// List cell
// Holds one list entry and its match flag; trades data with its neighbors.
// ----------------------------------------------------------------------------
module bsl_cell
    import bsl_pkg::*;
#(
    parameter int INDEX      = 0,
    parameter int PW         = 7,
    parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cell_ctl             i_ctl,
    input  logic [PW-1:0]         i_pos,
    input  logic [PW-1:0]         i_count,
    input  logic [DATA_WIDTH-1:0] i_value,
    input  logic [DATA_WIDTH-1:0] i_prev_word,
    input  logic [DATA_WIDTH-1:0] i_next_word,
    input  logic                  i_next_flag,
    output logic [DATA_WIDTH-1:0] o_word,
    output logic                  o_flag
);

    localparam logic [PW-1:0] IDX = PW'(INDEX);

    logic [DATA_WIDTH-1:0] r_word;
    logic [DATA_WIDTH-1:0] n_word;
    logic                  r_flag;
    logic                  n_flag;
    logic                  w_at_pos;
    logic                  w_above;

    assign w_at_pos = (IDX == i_pos);
    assign w_above  = (IDX > i_pos);

    always_comb begin
        n_word = r_word;
        if (i_ctl.shift_up) begin
            if (w_at_pos) begin
                n_word = i_value;
            end else if (w_above) begin
                n_word = i_prev_word;
            end
        end else if (i_ctl.shift_down) begin
            if (w_at_pos || w_above) begin
                n_word = i_next_word;
            end
        end else if (i_ctl.load && w_at_pos) begin
            n_word = i_value;
        end
    end

    always_comb begin
        n_flag = r_flag;
        if (i_ctl.capture) begin
            n_flag = (IDX < i_count) && (r_word == i_value);
        end else if (i_ctl.scan) begin
            n_flag = i_next_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else begin
            r_flag <= n_flag;
        end
    end

    assign o_word = r_word;
    assign o_flag = r_flag;

endmodule
